[rtl/oep_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oep_pkg
// Shared constants, register indexes and helpers for the orbit eye position core.
// ----------------------------------------------------------------------------
package oep_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    localparam logic [2:0] REG_RADIUS_START  = 3'd0;
    localparam logic [2:0] REG_RADIUS_DELTA  = 3'd1;
    localparam logic [2:0] REG_POLAR_START   = 3'd2;
    localparam logic [2:0] REG_POLAR_DELTA   = 3'd3;
    localparam logic [2:0] REG_AZIMUTH_START = 3'd4;
    localparam logic [2:0] REG_AZIMUTH_DELTA = 3'd5;
    localparam logic [2:0] REG_EYE_SCALE     = 3'd6;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // quarter-wave sine polynomial, Horner order
    localparam logic [31:0] POLY_COEF [0:6] = '{
        32'd61, 32'd3864, 32'd172272, 32'd5026995,
        32'd85569306, 32'd693598668, 32'd1686629713
    };

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = -32'sh8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX))
            r = S32_MAX;
        else if (v < 64'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/orbit_eye_position_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// orbit_eye_position_core
// Orbit camera eye position: interpolated spherical coordinates to Cartesian.
// ----------------------------------------------------------------------------
// One item enters per cycle while in_stall is low. The depth comes from the
// input and argument registers, the sine pipeline (square, six Horner steps,
// final scale), two product stages that combine sines with the radius and
// the output add; no stage is more than one multiply deep. All stages advance
// together unless out_stall holds a finished result, which raises in_stall.
// ----------------------------------------------------------------------------
module orbit_eye_position_core
    import oep_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [16:0]        progress,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      eye_x,
    output logic signed [31:0]      eye_y,
    output logic signed [31:0]      eye_z
);

    localparam int DEPTH = 13;
    localparam int CDLY  = 12;

    logic [30:0]        radius_start_reg;
    logic signed [31:0] radius_delta_reg;
    logic [15:0]        polar_start_reg;
    logic signed [31:0] polar_delta_reg;
    logic [15:0]        azimuth_start_reg;
    logic signed [31:0] azimuth_delta_reg;
    logic [30:0]        eye_scale_reg;

    logic [DEPTH:1] valid_reg;
    logic           adv;

    logic signed [31:0] cx_reg [1:CDLY];
    logic signed [31:0] cy_reg [1:CDLY];
    logic signed [31:0] cz_reg [1:CDLY];

    logic [31:0]        pa_reg;
    logic [31:0]        aa_reg;
    logic signed [48:0] rd_reg;

    logic [ANGLE_BITS-1:0] ph [0:3];
    logic [30:0]           x_next [0:3];
    logic [30:0]           x_reg [0:3];
    logic                  neg_reg [0:3];
    logic signed [31:0]    rl_reg;
    logic signed [33:0]    rl_sum;

    logic signed [63:0] rr_reg;
    logic signed [31:0] r_reg [4:11];

    logic signed [31:0] sn [0:3];

    logic signed [31:0] xyx_reg;
    logic signed [31:0] xyy_reg;
    logic signed [33:0] ez11_reg;
    logic signed [33:0] ez12_reg;
    logic signed [33:0] ex_reg;
    logic signed [33:0] ey_reg;
    logic signed [63:0] pxx;
    logic signed [63:0] pxy;
    logic signed [63:0] pz;
    logic signed [63:0] qx;
    logic signed [63:0] qy;

    logic signed [31:0] ox_reg;
    logic signed [31:0] oy_reg;
    logic signed [31:0] oz_reg;

    assign adv      = !(valid_reg[DEPTH] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_start_reg  <= 31'd65536;
            radius_delta_reg  <= '0;
            polar_start_reg   <= '0;
            polar_delta_reg   <= '0;
            azimuth_start_reg <= '0;
            azimuth_delta_reg <= '0;
            eye_scale_reg     <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS_START:  radius_start_reg  <= cfg_data[30:0];
                REG_RADIUS_DELTA:  radius_delta_reg  <= cfg_data;
                REG_POLAR_START:   polar_start_reg   <= cfg_data[15:0];
                REG_POLAR_DELTA:   polar_delta_reg   <= cfg_data;
                REG_AZIMUTH_START: azimuth_start_reg <= cfg_data[15:0];
                REG_AZIMUTH_DELTA: azimuth_delta_reg <= cfg_data;
                REG_EYE_SCALE:     eye_scale_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[DEPTH-1:1], in_valid};
    end

    // phase to quarter-wave argument
    always_comb
    begin
        ph[0] = pa_reg[31 -: ANGLE_BITS];
        ph[1] = pa_reg[31 -: ANGLE_BITS] + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
        ph[2] = aa_reg[31 -: ANGLE_BITS];
        ph[3] = aa_reg[31 -: ANGLE_BITS] + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
        for (int i = 0; i < 4; i++)
        begin
            x_next[i] = 31'({ph[i][ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}});
            if (ph[i][ANGLE_BITS-2])
                x_next[i] = Q30_ONE - x_next[i];
        end
        rl_sum = 34'($signed({1'b0, radius_start_reg})) + 34'(rd_reg >>> 16);
    end

    always_comb
    begin
        pxx = 64'(sn[0]) * 64'(sn[3]);
        pxy = 64'(sn[0]) * 64'(sn[2]);
        pz  = 64'(sn[1]) * 64'(r_reg[10]);
        qx  = 64'(xyx_reg) * 64'(r_reg[11]);
        qy  = 64'(xyy_reg) * 64'(r_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[1] <= center_x;
            cy_reg[1] <= center_y;
            cz_reg[1] <= center_z;
            for (int k = 2; k <= CDLY; k++)
            begin
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
                cz_reg[k] <= cz_reg[k-1];
            end

            pa_reg <= {polar_start_reg, 16'd0}
                      + 32'($unsigned(polar_delta_reg) * 32'(progress));
            aa_reg <= {azimuth_start_reg, 16'd0}
                      + 32'($unsigned(azimuth_delta_reg) * 32'(progress));
            rd_reg <= 49'(radius_delta_reg) * 49'($signed({1'b0, progress}));

            for (int i = 0; i < 4; i++)
            begin
                x_reg[i]   <= x_next[i];
                neg_reg[i] <= ph[i][ANGLE_BITS-1];
            end
            rl_reg <= sat32(64'(rl_sum));

            rr_reg   <= 64'(rl_reg) * 64'($signed({1'b0, eye_scale_reg}));
            r_reg[4] <= sat32(rr_reg >>> 16);
            for (int k = 5; k <= 11; k++)
                r_reg[k] <= r_reg[k-1];

            xyx_reg  <= 32'(pxx >>> 30);
            xyy_reg  <= 32'(pxy >>> 30);
            ez11_reg <= 34'(pz >>> 30);

            ex_reg   <= 34'(qx >>> 30);
            ey_reg   <= 34'(qy >>> 30);
            ez12_reg <= ez11_reg;

            ox_reg <= sat32(64'(cx_reg[CDLY]) + 64'(ex_reg));
            oy_reg <= sat32(64'(cy_reg[CDLY]) + 64'(ey_reg));
            oz_reg <= sat32(64'(cz_reg[CDLY]) + 64'(ez12_reg));
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_sine
        oep_sine u_sine (
            .clk    (clk),
            .en     (adv),
            .x_in   (x_reg[g]),
            .neg_in (neg_reg[g]),
            .sine   (sn[g])
        );
    end

    assign out_valid = valid_reg[DEPTH];
    assign eye_x     = ox_reg;
    assign eye_y     = oy_reg;
    assign eye_z     = oz_reg;

endmodule
`default_nettype wire

[rtl/oep_sine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oep_sine
// Pipelined quarter-wave sine: square, six Horner steps, final scale and sign.
// One item per enabled cycle.
// ----------------------------------------------------------------------------
module oep_sine
    import oep_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [30:0]        x_in,
    input  wire logic               neg_in,
    output logic signed [31:0]      sine
);

    logic [30:0] x_reg   [0:6];
    logic [30:0] x2_reg  [0:5];
    logic        neg_reg [0:6];
    logic [31:0] p_reg   [1:6];
    logic signed [31:0] s_reg;
    logic signed [31:0] s_next;
    logic [63:0] last_prod;
    logic [31:0] mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x_in;
            neg_reg[0] <= neg_in;
            x2_reg[0]  <= 31'((64'(x_in) * 64'(x_in)) >> 30);
            p_reg[1]   <= POLY_COEF[1]
                - 32'((64'(POLY_COEF[0]) * 64'(x2_reg[0])) >> 30);
            for (int k = 1; k <= 6; k++)
            begin
                x_reg[k]   <= x_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int k = 1; k <= 5; k++)
                x2_reg[k] <= x2_reg[k-1];
            for (int k = 2; k <= 6; k++)
                p_reg[k] <= POLY_COEF[k]
                    - 32'((64'(p_reg[k-1]) * 64'(x2_reg[k-1])) >> 30);
            s_reg <= s_next;
        end
    end

    always_comb
    begin
        last_prod = (64'(p_reg[6]) * 64'(x_reg[6])) >> 30;
        if (last_prod > 64'(Q30_ONE))
            mag = 32'(Q30_ONE);
        else
            mag = last_prod[31:0];
        s_next = neg_reg[6] ? -$signed(mag) : $signed(mag);
    end

    assign sine = s_reg;

endmodule
`default_nettype wire
